// ----- design/oit_pkg.sv -----
// Shared types, codes and widths for the ordered incidence table.
package oit_pkg;

	// Field widths of the item payloads
	localparam int OP_W    = 2;
	localparam int FIELD_W = 3;

	// Width of the microprogram step counter
	localparam int PC_W = 6;

	// Op codes of the input item
	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_LIST_ROW = 2'd2,
		OP_LIST_COL = 2'd3
	} op_t;

	// Result status codes
	localparam logic [FIELD_W-1:0] ST_OK     = 3'd0;
	localparam logic [FIELD_W-1:0] ST_DUP    = 3'd1;
	localparam logic [FIELD_W-1:0] ST_ABSENT = 3'd2;
	localparam logic [FIELD_W-1:0] ST_ITEM   = 3'd3;
	localparam logic [FIELD_W-1:0] ST_EMPTY  = 3'd4;

	// Datapath actions of one control word
	typedef enum logic [3:0] {
		ACT_NONE,      // no datapath effect
		ACT_CLRK,      // clear the list index
		ACT_RD,        // read the entry at the index
		ACT_RDN,       // read the entry after the index
		ACT_CMP,       // compare read entry with key, advance index on miss
		ACT_WRK,       // write read entry at the index, advance index
		ACT_APPEND,    // append key at the list end if there is room
		ACT_DEC,       // shorten the list by one
		ACT_EMIT,      // send a status result
		ACT_EMIT_ITEM  // send the read entry as a list item, advance index
	} act_t;

	// Jump conditions of one control word
	typedef enum logic [2:0] {
		CND_NEXT,   // fall through
		CND_ALWAYS, // jump
		CND_START,  // wait for an item, then dispatch on its op
		CND_LENZ,   // jump if the list is empty
		CND_MATCH,  // jump if the read entry equals the key
		CND_KLT,    // jump if the index is below the list length
		CND_KLAST   // jump if the index is at the last list entry or beyond
	} cond_t;

	// One microprogram step
	typedef struct packed {
		logic                sel;    // 0 row list, 1 column list
		act_t                act;
		cond_t               cond;
		logic [PC_W-1:0]     target;
		logic [FIELD_W-1:0]  status;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic                load;   // capture the incoming item
		logic                sel;
		act_t                act;
		logic [FIELD_W-1:0]  status;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic [OP_W-1:0] in_op;
		logic            in_user_ok;
		logic            in_coupon_ok;
		logic            lenz;
		logic            match;
		logic            klt;
		logic            klast;
		logic            obusy;
	} flags_t;

endpackage

// ----- design/ordered_incidence_table_unit.sv -----
// Top level of the ordered incidence table between users and coupons.
// Keeps, for every user (row) and every coupon (column), the list of its partners in the
// order they were added. Add appends a pair to both lists (a pair already present is
// ignored with a duplicate status), remove takes it out of both and closes the gaps (an
// absent pair is flagged), and the two queries send a row's coupons or a column's users,
// one result per member with tlast on the final one, or one empty result. A small
// microprogram walks the lists one entry at a time through two entry memories with
// registered reads, one for rows and one for columns. An item with a field out of range
// goes straight to its status result, and a query of an empty list to the empty result;
// output stalls hold any result step. The search, shift and list loops spend three steps
// (read, use, branch) per entry. A new item is taken only when the sequencer is back at
// its idle step, while the last result may still wait in the output register.
module ordered_incidence_table_unit #(
	parameter int NUM_USERS   = 5,
	parameter int NUM_COUPONS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // op[1:0], user[4:2], coupon[7:5]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // status[2:0], item[5:3], zero[7:6]
	output logic       m_tlast
);

	oit_pkg::ctl_t   ctl;
	oit_pkg::flags_t flags;

	// Step through the microprogram
	oit_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.flags    (flags),
		.ctl      (ctl)
	);

	// Hold the lists and drive results
	oit_dp #(
		.NUM_USERS   (NUM_USERS),
		.NUM_COUPONS (NUM_COUPONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.ctl      (ctl),
		.flags    (flags),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- design/oit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module oit_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 20
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/oit_seq.sv -----
// Microprogram sequencer: step counter, control store and op dispatch.
module oit_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  oit_pkg::flags_t flags,
	output oit_pkg::ctl_t   ctl
);

	// Entry points and jump targets of the microprogram
	localparam logic [oit_pkg::PC_W-1:0] S_IDLE     = 6'd0;
	localparam logic [oit_pkg::PC_W-1:0] S_ADD      = 6'd1;
	localparam logic [oit_pkg::PC_W-1:0] S_ADD_RD   = 6'd2;
	localparam logic [oit_pkg::PC_W-1:0] S_ADD_APP  = 6'd5;
	localparam logic [oit_pkg::PC_W-1:0] S_ADD_OK   = 6'd7;
	localparam logic [oit_pkg::PC_W-1:0] S_ADD_DUP  = 6'd8;
	localparam logic [oit_pkg::PC_W-1:0] S_REM      = 6'd9;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_RD   = 6'd10;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_ABS  = 6'd13;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_RSH  = 6'd14;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_RDEC = 6'd17;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_COL  = 6'd18;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_CRD  = 6'd19;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_CSH  = 6'd23;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_CDEC = 6'd26;
	localparam logic [oit_pkg::PC_W-1:0] S_REM_OK   = 6'd27;
	localparam logic [oit_pkg::PC_W-1:0] S_LROW     = 6'd28;
	localparam logic [oit_pkg::PC_W-1:0] S_LROW_RD  = 6'd29;
	localparam logic [oit_pkg::PC_W-1:0] S_EMPTY    = 6'd32;
	localparam logic [oit_pkg::PC_W-1:0] S_LCOL     = 6'd33;
	localparam logic [oit_pkg::PC_W-1:0] S_LCOL_RD  = 6'd34;

	localparam logic ROW = 1'b0;
	localparam logic COL = 1'b1;

	// Build one control word
	function automatic oit_pkg::uword_t uw(
		input logic                          sel,
		input oit_pkg::act_t                 act,
		input oit_pkg::cond_t                cond,
		input logic [oit_pkg::PC_W-1:0]      target,
		input logic [oit_pkg::FIELD_W-1:0]   status
	);
		oit_pkg::uword_t w;
		w.sel    = sel;
		w.act    = act;
		w.cond   = cond;
		w.target = target;
		w.status = status;
		return w;
	endfunction

	// Control store
	function automatic oit_pkg::uword_t rom(input logic [oit_pkg::PC_W-1:0] a);
		oit_pkg::uword_t w;
		case (a)
			S_IDLE:     w = uw(ROW, oit_pkg::ACT_NONE, oit_pkg::CND_START, S_IDLE, oit_pkg::ST_OK);
			// add: search the row for the coupon, then append to both lists
			S_ADD:      w = uw(ROW, oit_pkg::ACT_CLRK, oit_pkg::CND_LENZ, S_ADD_APP, oit_pkg::ST_OK);
			S_ADD_RD:   w = uw(ROW, oit_pkg::ACT_RD, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd3:       w = uw(ROW, oit_pkg::ACT_CMP, oit_pkg::CND_MATCH, S_ADD_DUP, oit_pkg::ST_OK);
			6'd4:       w = uw(ROW, oit_pkg::ACT_NONE, oit_pkg::CND_KLT, S_ADD_RD, oit_pkg::ST_OK);
			S_ADD_APP:  w = uw(ROW, oit_pkg::ACT_APPEND, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd6:       w = uw(COL, oit_pkg::ACT_APPEND, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			S_ADD_OK:   w = uw(ROW, oit_pkg::ACT_EMIT, oit_pkg::CND_ALWAYS, S_IDLE, oit_pkg::ST_OK);
			S_ADD_DUP:  w = uw(ROW, oit_pkg::ACT_EMIT, oit_pkg::CND_ALWAYS, S_IDLE, oit_pkg::ST_DUP);
			// remove: search the row, close its gap, then the same on the column
			S_REM:      w = uw(ROW, oit_pkg::ACT_CLRK, oit_pkg::CND_LENZ, S_REM_ABS, oit_pkg::ST_OK);
			S_REM_RD:   w = uw(ROW, oit_pkg::ACT_RD, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd11:      w = uw(ROW, oit_pkg::ACT_CMP, oit_pkg::CND_MATCH, S_REM_RSH, oit_pkg::ST_OK);
			6'd12:      w = uw(ROW, oit_pkg::ACT_NONE, oit_pkg::CND_KLT, S_REM_RD, oit_pkg::ST_OK);
			S_REM_ABS:  w = uw(ROW, oit_pkg::ACT_EMIT, oit_pkg::CND_ALWAYS, S_IDLE,
				oit_pkg::ST_ABSENT);
			S_REM_RSH:  w = uw(ROW, oit_pkg::ACT_NONE, oit_pkg::CND_KLAST, S_REM_RDEC, oit_pkg::ST_OK);
			6'd15:      w = uw(ROW, oit_pkg::ACT_RDN, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd16:      w = uw(ROW, oit_pkg::ACT_WRK, oit_pkg::CND_ALWAYS, S_REM_RSH, oit_pkg::ST_OK);
			S_REM_RDEC: w = uw(ROW, oit_pkg::ACT_DEC, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			S_REM_COL:  w = uw(COL, oit_pkg::ACT_CLRK, oit_pkg::CND_LENZ, S_REM_OK, oit_pkg::ST_OK);
			S_REM_CRD:  w = uw(COL, oit_pkg::ACT_RD, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd20:      w = uw(COL, oit_pkg::ACT_CMP, oit_pkg::CND_MATCH, S_REM_CSH, oit_pkg::ST_OK);
			6'd21:      w = uw(COL, oit_pkg::ACT_NONE, oit_pkg::CND_KLT, S_REM_CRD, oit_pkg::ST_OK);
			6'd22:      w = uw(COL, oit_pkg::ACT_NONE, oit_pkg::CND_ALWAYS, S_REM_OK, oit_pkg::ST_OK);
			S_REM_CSH:  w = uw(COL, oit_pkg::ACT_NONE, oit_pkg::CND_KLAST, S_REM_CDEC, oit_pkg::ST_OK);
			6'd24:      w = uw(COL, oit_pkg::ACT_RDN, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd25:      w = uw(COL, oit_pkg::ACT_WRK, oit_pkg::CND_ALWAYS, S_REM_CSH, oit_pkg::ST_OK);
			S_REM_CDEC: w = uw(COL, oit_pkg::ACT_DEC, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			S_REM_OK:   w = uw(ROW, oit_pkg::ACT_EMIT, oit_pkg::CND_ALWAYS, S_IDLE, oit_pkg::ST_OK);
			// list a row: read and send each entry
			S_LROW:     w = uw(ROW, oit_pkg::ACT_CLRK, oit_pkg::CND_LENZ, S_EMPTY, oit_pkg::ST_OK);
			S_LROW_RD:  w = uw(ROW, oit_pkg::ACT_RD, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd30:      w = uw(ROW, oit_pkg::ACT_EMIT_ITEM, oit_pkg::CND_KLAST, S_IDLE,
				oit_pkg::ST_ITEM);
			6'd31:      w = uw(ROW, oit_pkg::ACT_NONE, oit_pkg::CND_ALWAYS, S_LROW_RD, oit_pkg::ST_OK);
			S_EMPTY:    w = uw(ROW, oit_pkg::ACT_EMIT, oit_pkg::CND_ALWAYS, S_IDLE, oit_pkg::ST_EMPTY);
			// list a column
			S_LCOL:     w = uw(COL, oit_pkg::ACT_CLRK, oit_pkg::CND_LENZ, S_EMPTY, oit_pkg::ST_OK);
			S_LCOL_RD:  w = uw(COL, oit_pkg::ACT_RD, oit_pkg::CND_NEXT, S_IDLE, oit_pkg::ST_OK);
			6'd35:      w = uw(COL, oit_pkg::ACT_EMIT_ITEM, oit_pkg::CND_KLAST, S_IDLE,
				oit_pkg::ST_ITEM);
			6'd36:      w = uw(COL, oit_pkg::ACT_NONE, oit_pkg::CND_ALWAYS, S_LCOL_RD, oit_pkg::ST_OK);
			default:    w = uw(ROW, oit_pkg::ACT_NONE, oit_pkg::CND_ALWAYS, S_IDLE, oit_pkg::ST_OK);
		endcase
		return w;
	endfunction

	logic [oit_pkg::PC_W-1:0] pc_q;
	logic [oit_pkg::PC_W-1:0] pc_d;
	logic [oit_pkg::PC_W-1:0] disp;
	oit_pkg::uword_t          word;
	logic                     take;
	logic                     stall;

	// Fetch the current step
	assign word     = rom(pc_q);
	assign s_tready = (pc_q == S_IDLE);
	assign take     = s_tready && s_tvalid;

	// Hold an emit step while the output register is still full
	assign stall = ((word.act == oit_pkg::ACT_EMIT) || (word.act == oit_pkg::ACT_EMIT_ITEM))
		&& flags.obusy;

	// Drive the datapath
	always_comb begin
		ctl.load   = take;
		ctl.sel    = word.sel;
		ctl.status = word.status;
		ctl.act    = stall ? oit_pkg::ACT_NONE : word.act;
	end

	// Pick the entry point for the incoming item
	always_comb begin
		unique case (flags.in_op)
			oit_pkg::OP_ADD:      disp = (flags.in_user_ok && flags.in_coupon_ok) ? S_ADD : S_REM_ABS;
			oit_pkg::OP_REMOVE:   disp = (flags.in_user_ok && flags.in_coupon_ok) ? S_REM : S_REM_ABS;
			oit_pkg::OP_LIST_ROW: disp = flags.in_user_ok ? S_LROW : S_EMPTY;
			oit_pkg::OP_LIST_COL: disp = flags.in_coupon_ok ? S_LCOL : S_EMPTY;
			default:              disp = S_EMPTY;
		endcase
	end

	// Advance or jump
	always_comb begin
		if (stall) begin
			pc_d = pc_q;
		end else begin
			unique case (word.cond)
				oit_pkg::CND_NEXT:   pc_d = pc_q + 1'b1;
				oit_pkg::CND_ALWAYS: pc_d = word.target;
				oit_pkg::CND_START:  pc_d = take ? disp : pc_q;
				oit_pkg::CND_LENZ:   pc_d = flags.lenz ? word.target : pc_q + 1'b1;
				oit_pkg::CND_MATCH:  pc_d = flags.match ? word.target : pc_q + 1'b1;
				oit_pkg::CND_KLT:    pc_d = flags.klt ? word.target : pc_q + 1'b1;
				oit_pkg::CND_KLAST:  pc_d = flags.klast ? word.target : pc_q + 1'b1;
				default:             pc_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- design/oit_dp.sv -----
// Datapath: item registers, list lengths, entry memories and the output register.
module oit_dp #(
	parameter int NUM_USERS   = 5,
	parameter int NUM_COUPONS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      s_tdata,
	input  oit_pkg::ctl_t   ctl,
	output oit_pkg::flags_t flags,
	input  logic            m_tready,
	output logic            m_tvalid,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	localparam int DEPTH = NUM_USERS * NUM_COUPONS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int UW    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int CW    = (NUM_COUPONS > 1) ? $clog2(NUM_COUPONS) : 1;
	localparam int RLW   = $clog2(NUM_COUPONS + 1);
	localparam int CLW   = $clog2(NUM_USERS + 1);
	localparam int MAXN  = (NUM_USERS > NUM_COUPONS) ? NUM_USERS : NUM_COUPONS;
	localparam int LW    = $clog2(MAXN + 1);
	localparam int FW    = oit_pkg::FIELD_W;

	logic [FW-1:0]  user_q;
	logic [FW-1:0]  coupon_q;
	logic [LW-1:0]  k_q;
	logic [RLW-1:0] row_len_q [NUM_USERS];
	logic [CLW-1:0] col_len_q [NUM_COUPONS];
	logic           out_valid_q;
	logic [FW-1:0]  status_q;
	logic [FW-1:0]  item_q;
	logic           last_q;

	logic [FW-1:0]  in_user;
	logic [FW-1:0]  in_coupon;
	logic [UW-1:0]  u_idx;
	logic [CW-1:0]  c_idx;
	logic [LW-1:0]  cur_len;
	logic [LW-1:0]  cap;
	logic [LW:0]    k_inc;
	logic [LW-1:0]  offset;
	logic [FW-1:0]  key;
	logic [FW-1:0]  rdata;
	logic [FW-1:0]  row_rd;
	logic [FW-1:0]  col_rd;
	logic [AW-1:0]  addr;
	logic [FW-1:0]  wdata;
	logic           room;
	logic           re;
	logic           we;

	// Split the incoming item
	assign in_user   = s_tdata[4:2];
	assign in_coupon = s_tdata[7:5];

	// Select the current list
	assign u_idx   = UW'(user_q);
	assign c_idx   = CW'(coupon_q - 1'b1);
	assign cur_len = ctl.sel ? LW'(col_len_q[c_idx]) : LW'(row_len_q[u_idx]);
	assign cap     = ctl.sel ? LW'(NUM_USERS) : LW'(NUM_COUPONS);
	assign key     = ctl.sel ? user_q : coupon_q;
	assign rdata   = ctl.sel ? col_rd : row_rd;
	assign k_inc   = (LW + 1)'(k_q) + (LW + 1)'(1);
	assign room    = cur_len < cap;

	// Form the entry address inside the current list
	always_comb begin
		case (ctl.act)
			oit_pkg::ACT_RDN:    offset = k_inc[LW-1:0];
			oit_pkg::ACT_APPEND: offset = cur_len;
			default:             offset = k_q;
		endcase
		if (ctl.sel) begin
			addr = AW'(32'(c_idx) * NUM_USERS + 32'(offset));
		end else begin
			addr = AW'(32'(u_idx) * NUM_COUPONS + 32'(offset));
		end
	end

	assign re    = (ctl.act == oit_pkg::ACT_RD) || (ctl.act == oit_pkg::ACT_RDN);
	assign we    = (ctl.act == oit_pkg::ACT_WRK) || ((ctl.act == oit_pkg::ACT_APPEND) && room);
	assign wdata = (ctl.act == oit_pkg::ACT_WRK) ? rdata : key;

	// Row lists hold coupon numbers
	oit_ram #(
		.WIDTH (FW),
		.DEPTH (DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (we && !ctl.sel),
		.waddr (addr),
		.wdata (wdata),
		.re    (re && !ctl.sel),
		.raddr (addr),
		.rdata (row_rd)
	);

	// Column lists hold user indices
	oit_ram #(
		.WIDTH (FW),
		.DEPTH (DEPTH)
	) u_col_ram (
		.clk   (clk),
		.we    (we && ctl.sel),
		.waddr (addr),
		.wdata (wdata),
		.re    (re && ctl.sel),
		.raddr (addr),
		.rdata (col_rd)
	);

	// Report conditions to the sequencer
	always_comb begin
		flags.in_op        = s_tdata[1:0];
		flags.in_user_ok   = 32'(in_user) < NUM_USERS;
		flags.in_coupon_ok = (in_coupon != '0) && (32'(in_coupon) <= NUM_COUPONS);
		flags.lenz         = cur_len == '0;
		flags.match        = rdata == key;
		flags.klt          = k_q < cur_len;
		flags.klast        = k_inc >= (LW + 1)'(cur_len);
		flags.obusy        = out_valid_q && !m_tready;
	end

	// Update index, lengths and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_USERS; i++) begin
				row_len_q[i] <= '0;
			end
			for (int j = 0; j < NUM_COUPONS; j++) begin
				col_len_q[j] <= '0;
			end
		end else begin
			case (ctl.act)
				oit_pkg::ACT_CLRK: begin
					k_q <= '0;
				end
				oit_pkg::ACT_CMP: begin
					if (!flags.match) begin
						k_q <= k_inc[LW-1:0];
					end
				end
				oit_pkg::ACT_WRK, oit_pkg::ACT_EMIT_ITEM: begin
					k_q <= k_inc[LW-1:0];
				end
				oit_pkg::ACT_APPEND: begin
					if (room) begin
						if (ctl.sel) begin
							col_len_q[c_idx] <= col_len_q[c_idx] + 1'b1;
						end else begin
							row_len_q[u_idx] <= row_len_q[u_idx] + 1'b1;
						end
					end
				end
				oit_pkg::ACT_DEC: begin
					if (ctl.sel) begin
						col_len_q[c_idx] <= col_len_q[c_idx] - 1'b1;
					end else begin
						row_len_q[u_idx] <= row_len_q[u_idx] - 1'b1;
					end
				end
				default: begin
				end
			endcase
			if ((ctl.act == oit_pkg::ACT_EMIT) || (ctl.act == oit_pkg::ACT_EMIT_ITEM)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the item fields and load result payloads
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			user_q   <= in_user;
			coupon_q <= in_coupon;
		end
		if (ctl.act == oit_pkg::ACT_EMIT) begin
			status_q <= ctl.status;
			item_q   <= '0;
			last_q   <= 1'b1;
		end else if (ctl.act == oit_pkg::ACT_EMIT_ITEM) begin
			status_q <= oit_pkg::ST_ITEM;
			item_q   <= rdata;
			last_q   <= flags.klast;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, item_q, status_q};
	assign m_tlast  = last_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the ordered incidence table unit.
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_USERS    = 5;
	localparam int NUM_COUPONS  = 4;
	localparam int RANDOM_ITEMS = 195;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] item;
		logic       last;
	} result_t;

	// Mirror of the table contents and the queue of results still owed by the block
	class incidence_book;
		result_t    pending[$];
		int         errors;
		logic [2:0] row_list[NUM_USERS][NUM_COUPONS];
		int         row_len[NUM_USERS];
		logic [2:0] column_list[NUM_COUPONS][NUM_USERS];
		int         column_len[NUM_COUPONS];

		function new();
			errors = 0;
			foreach (row_len[i]) row_len[i] = 0;
			foreach (column_len[i]) column_len[i] = 0;
		endfunction

		function void queue_result(logic [2:0] status, logic [2:0] item, logic last);
			result_t r;
			r.status = status;
			r.item   = item;
			r.last   = last;
			pending.push_back(r);
		endfunction

		// Update the mirror for one accepted item and queue what it must produce
		function void note_request(oit_pkg::op_t op, logic [2:0] user, logic [2:0] coupon);
			bit user_ok;
			bit coupon_ok;
			int u;
			int c;
			int rpos;
			int cpos;
			user_ok   = user < NUM_USERS;
			coupon_ok = coupon >= 1 && coupon <= NUM_COUPONS;
			u = user_ok ? int'(user) : 0;
			c = coupon_ok ? int'(coupon) - 1 : 0;
			case (op)
			oit_pkg::OP_ADD, oit_pkg::OP_REMOVE: begin
				if (!user_ok || !coupon_ok) begin
					queue_result(oit_pkg::ST_ABSENT, 3'd0, 1'b1);
					return;
				end
				rpos = -1;
				for (int k = 0; k < row_len[u]; k++)
					if (rpos < 0 && row_list[u][k] == coupon) rpos = k;
				if (op == oit_pkg::OP_ADD) begin
					if (rpos >= 0) begin
						queue_result(oit_pkg::ST_DUP, 3'd0, 1'b1);
					end else begin
						if (row_len[u] < NUM_COUPONS) begin
							row_list[u][row_len[u]] = coupon;
							row_len[u]++;
						end
						if (column_len[c] < NUM_USERS) begin
							column_list[c][column_len[c]] = 3'(u);
							column_len[c]++;
						end
						queue_result(oit_pkg::ST_OK, 3'd0, 1'b1);
					end
				end else if (rpos < 0) begin
					queue_result(oit_pkg::ST_ABSENT, 3'd0, 1'b1);
				end else begin
					// close the gap in the row, then in the column
					for (int k = rpos; k + 1 < row_len[u]; k++)
						row_list[u][k] = row_list[u][k + 1];
					row_len[u]--;
					cpos = -1;
					for (int k = 0; k < column_len[c]; k++)
						if (cpos < 0 && column_list[c][k] == 3'(u)) cpos = k;
					if (cpos >= 0) begin
						for (int k = cpos; k + 1 < column_len[c]; k++)
							column_list[c][k] = column_list[c][k + 1];
						column_len[c]--;
					end
					queue_result(oit_pkg::ST_OK, 3'd0, 1'b1);
				end
			end
			oit_pkg::OP_LIST_ROW: begin
				if (!user_ok || row_len[u] == 0) begin
					queue_result(oit_pkg::ST_EMPTY, 3'd0, 1'b1);
				end else begin
					for (int k = 0; k < row_len[u]; k++)
						queue_result(oit_pkg::ST_ITEM, row_list[u][k], k == row_len[u] - 1);
				end
			end
			default: begin
				if (!coupon_ok || column_len[c] == 0) begin
					queue_result(oit_pkg::ST_EMPTY, 3'd0, 1'b1);
				end else begin
					for (int k = 0; k < column_len[c]; k++)
						queue_result(oit_pkg::ST_ITEM, column_list[c][k],
							k == column_len[c] - 1);
				end
			end
			endcase
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(logic [7:0] data, logic last);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status %0d item %0d last %0d",
					$time, data[2:0], data[5:3], last);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[2:0] !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, data[2:0]);
				errors++;
			end
			if (data[5:3] !== want.item) begin
				$display("%0t: item expected %0d actual %0d", $time, want.item, data[5:3]);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last expected %0d actual %0d", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // op[1:0], user[4:2], coupon[7:5]
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // status[2:0], item[5:3], zero[7:6]
	logic       m_tlast;

	incidence_book book = new();
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int cycle_count = 0;

	ordered_incidence_table_unit #(
		.NUM_USERS(NUM_USERS),
		.NUM_COUPONS(NUM_COUPONS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ordered_incidence_table_unit test failed");
			$finish;
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_item(oit_pkg::op_t op, logic [2:0] user, logic [2:0] coupon);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {coupon, user, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		book.note_request(op, user, coupon);
		if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
	endtask

	// Mostly legal fields, now and then an out-of-range one
	task automatic send_random_item();
		oit_pkg::op_t op;
		logic [2:0]   user;
		logic [2:0]   coupon;
		int           pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) op = oit_pkg::OP_ADD;
		else if (pick < 60) op = oit_pkg::OP_REMOVE;
		else if (pick < 80) op = oit_pkg::OP_LIST_ROW;
		else op = oit_pkg::OP_LIST_COL;
		user = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, NUM_USERS - 1));
		if ($urandom_range(0, 9) == 0) begin
			pick = $urandom_range(0, 3);
			coupon = (pick == 0) ? 3'd0 : 3'(pick + 4);
		end else begin
			coupon = 3'($urandom_range(1, NUM_COUPONS));
		end
		send_item(op, user, coupon);
	endtask

	// Accept results with random stalls and check each one
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			book.check_result(m_tdata, m_tlast);
			if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty lists and the basic add, duplicate and absent cases
		send_item(oit_pkg::OP_LIST_ROW, 3'd0, 3'd1);
		send_item(oit_pkg::OP_LIST_COL, 3'd0, 3'd4);
		send_item(oit_pkg::OP_ADD, 3'd0, 3'd1);
		send_item(oit_pkg::OP_ADD, 3'd0, 3'd1);
		send_item(oit_pkg::OP_REMOVE, 3'd1, 3'd2);
		// out-of-range user or coupon on add and remove
		send_item(oit_pkg::OP_ADD, 3'd7, 3'd1);
		send_item(oit_pkg::OP_ADD, 3'd2, 3'd0);
		send_item(oit_pkg::OP_REMOVE, 3'd5, 3'd7);
		// fill the last row and the last column completely
		send_item(oit_pkg::OP_ADD, 3'd4, 3'd4);
		send_item(oit_pkg::OP_ADD, 3'd4, 3'd2);
		send_item(oit_pkg::OP_ADD, 3'd4, 3'd1);
		send_item(oit_pkg::OP_ADD, 3'd4, 3'd3);
		send_item(oit_pkg::OP_ADD, 3'd1, 3'd4);
		send_item(oit_pkg::OP_ADD, 3'd2, 3'd4);
		send_item(oit_pkg::OP_ADD, 3'd3, 3'd4);
		send_item(oit_pkg::OP_ADD, 3'd0, 3'd4);
		send_item(oit_pkg::OP_LIST_ROW, 3'd4, 3'd0);
		send_item(oit_pkg::OP_LIST_COL, 3'd7, 3'd4);
		// remove from the middle and check order is kept
		send_item(oit_pkg::OP_REMOVE, 3'd4, 3'd2);
		send_item(oit_pkg::OP_REMOVE, 3'd2, 3'd4);
		send_item(oit_pkg::OP_LIST_ROW, 3'd4, 3'd7);
		send_item(oit_pkg::OP_LIST_COL, 3'd0, 3'd4);
		// queries with out-of-range selectors
		send_item(oit_pkg::OP_LIST_ROW, 3'd6, 3'd2);
		send_item(oit_pkg::OP_LIST_COL, 3'd3, 3'd0);
		send_item(oit_pkg::OP_LIST_COL, 3'd1, 3'd7);

		repeat (RANDOM_ITEMS) send_random_item();
		s_tvalid <= 1'b0;

		// drain outstanding results, then watch for stray ones
		while (book.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0) begin
			$display("ordered_incidence_table_unit test passed");
		end else begin
			$display("ordered_incidence_table_unit test failed");
		end
		$finish;
	end

endmodule
